// ----- sv/sttu_pkg.sv -----
// shared types and token kind codes of the source text tokenizer
package sttu_pkg;

  localparam int unsigned RES_DEPTH = 4;

  localparam logic [5:0] K_EOF           = 6'd0;
  localparam logic [5:0] K_IDENTIFIER    = 6'd1;
  localparam logic [5:0] K_NUMBER        = 6'd2;
  localparam logic [5:0] K_STRING        = 6'd3;
  localparam logic [5:0] K_ASSIGN        = 6'd4;
  localparam logic [5:0] K_DEFINE        = 6'd5;
  localparam logic [5:0] K_COLON         = 6'd6;
  localparam logic [5:0] K_SEMICOLON     = 6'd7;
  localparam logic [5:0] K_LPAREN        = 6'd8;
  localparam logic [5:0] K_RPAREN        = 6'd9;
  localparam logic [5:0] K_LBRACE        = 6'd10;
  localparam logic [5:0] K_RBRACE        = 6'd11;
  localparam logic [5:0] K_LBRACKET      = 6'd12;
  localparam logic [5:0] K_RBRACKET      = 6'd13;
  localparam logic [5:0] K_DOT           = 6'd14;
  localparam logic [5:0] K_COMMA         = 6'd15;
  localparam logic [5:0] K_QUESTION      = 6'd16;
  localparam logic [5:0] K_PIPE          = 6'd17;
  localparam logic [5:0] K_AT            = 6'd18;
  localparam logic [5:0] K_PLUS          = 6'd19;
  localparam logic [5:0] K_MINUS         = 6'd20;
  localparam logic [5:0] K_STAR          = 6'd21;
  localparam logic [5:0] K_SLASH         = 6'd22;
  localparam logic [5:0] K_PERCENT       = 6'd23;
  localparam logic [5:0] K_EQUAL         = 6'd24;
  localparam logic [5:0] K_NOT_EQUAL     = 6'd25;
  localparam logic [5:0] K_LESS          = 6'd26;
  localparam logic [5:0] K_GREATER       = 6'd27;
  localparam logic [5:0] K_LESS_EQUAL    = 6'd28;
  localparam logic [5:0] K_GREATER_EQUAL = 6'd29;
  localparam logic [5:0] K_ARROW         = 6'd30;
  localparam logic [5:0] K_KEYWORD       = 6'd31;
  localparam logic [5:0] K_BUILTIN       = 6'd32;
  localparam logic [5:0] K_UNKNOWN       = 6'd33;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [31:0] start_offset;
    logic [15:0] text_length;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] count;
  } scan_out_t;

endpackage

// ----- sv/sttu_channels.sv -----
// valid/ready channel interfaces for source bytes and tokens
interface sttu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface sttu_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [31:0] start_offset;
  logic [15:0] text_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_line, output start_column,
                  output start_offset, output text_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input start_line, input start_column,
                input start_offset, input text_length, input last_of_run, output ready);
endinterface

// ----- sv/sttu_scan.sv -----
// scanner state and per-byte token logic
module sttu_scan import sttu_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned LINE_WIDTH     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output scan_out_t  scan_o
);

  typedef enum logic [12:0] {
    M_IDLE    = 13'b0000000000001,
    M_NUMBER  = 13'b0000000000010,
    M_IDENT   = 13'b0000000000100,
    M_STRING  = 13'b0000000001000,
    M_AT0     = 13'b0000000010000,
    M_ATWORD  = 13'b0000000100000,
    M_EQ      = 13'b0000001000000,
    M_COLON1  = 13'b0000010000000,
    M_COLON2  = 13'b0000100000000,
    M_BANG    = 13'b0001000000000,
    M_MINUS   = 13'b0010000000000,
    M_LESS    = 13'b0100000000000,
    M_GREATER = 13'b1000000000000
  } mode_t;

  localparam logic [LINE_WIDTH-1:0]     LMAX = {LINE_WIDTH{1'b1}};
  localparam logic [POSITION_WIDTH-1:0] PMAX = {POSITION_WIDTH{1'b1}};
  localparam logic [15:0]               LEN_MAX = 16'hFFFF;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;

  // keyword set: loop, return, break, continue, then builtins std, this
  localparam logic [5:0] KW_WORDS    = 6'h0F;
  localparam logic [5:0] KW_BUILTINS = 6'h30;
  localparam logic [5:0] KW_ALL      = 6'h3F;
  localparam logic [7:0] KW_TEXT [6][8] = '{
    '{"l", "o", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"s", "t", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "h", "i", "s", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [6] = '{4'd4, 4'd6, 4'd5, 4'd8, 4'd3, 4'd4};

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [5:0] kw_step(logic [5:0] kw, logic [15:0] len, logic [7:0] c);
    logic [5:0] nk;
    for (int i = 0; i < 6; i++) begin
      nk[i] = kw[i] && (len < 16'(KW_LEN[i])) && (KW_TEXT[i][len[2:0]] == c);
    end
    return nk;
  endfunction

  function automatic logic word_match(logic [5:0] kw, logic [15:0] len);
    logic m;
    m = 1'b0;
    for (int i = 0; i < 6; i++) begin
      m = m | (kw[i] && (len == 16'(KW_LEN[i])));
    end
    return m;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "[": k = K_LBRACKET;
      "]": k = K_RBRACKET;
      ";": k = K_SEMICOLON;
      ",": k = K_COMMA;
      ".": k = K_DOT;
      "?": k = K_QUESTION;
      "|": k = K_PIPE;
      "+": k = K_PLUS;
      "*": k = K_STAR;
      "/": k = K_SLASH;
      "%": k = K_PERCENT;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic res_t mk(logic [5:0] k, logic [LINE_WIDTH-1:0] ln,
                              logic [LINE_WIDTH-1:0] cl, logic [POSITION_WIDTH-1:0] of,
                              logic [15:0] len);
    res_t r;
    r.token_kind   = k;
    r.start_line   = 16'(ln);
    r.start_column = 16'(cl);
    r.start_offset = 32'(of);
    r.text_length  = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  mode_t                     mode_r, mode_nxt;
  logic [LINE_WIDTH-1:0]     line_r, line_nxt, col_r, col_nxt;
  logic [LINE_WIDTH-1:0]     tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt, tstart_r, tstart_nxt;
  logic [15:0]               tlen_r, tlen_nxt;
  logic [5:0]                kw_r, kw_nxt;
  logic                      esc_r, esc_nxt;

  logic                      is_end, took, cons, fin, to_idle;
  logic [LINE_WIDTH-1:0]     line_cons, col_cons;
  logic [POSITION_WIDTH-1:0] pos_inc;
  logic [15:0]               len_inc;
  logic [5:0]                pend_k, fin_k;
  res_t                      cur, r0, r1, single;
  logic [1:0]                n;

  always_comb begin
    is_end  = end_of_input || (char_code == 8'd0);
    pos_inc = (pos_r != PMAX) ? pos_r + POSITION_WIDTH'(1) : pos_r;
    if (char_code == CH_NL) begin
      line_cons = (line_r != LMAX) ? line_r + LINE_WIDTH'(1) : line_r;
      col_cons  = LINE_WIDTH'(1);
    end else begin
      line_cons = line_r;
      col_cons  = (col_r != LMAX) ? col_r + LINE_WIDTH'(1) : col_r;
    end
    len_inc = (tlen_r != LEN_MAX) ? tlen_r + 16'd1 : tlen_r;

    // kind of the pending token if it ends here
    case (mode_r)
      M_NUMBER:  pend_k = K_NUMBER;
      M_IDENT:   pend_k = word_match(kw_r, tlen_r) ? K_KEYWORD : K_IDENTIFIER;
      M_STRING:  pend_k = K_STRING;
      M_AT0:     pend_k = K_AT;
      M_ATWORD:  pend_k = word_match(kw_r, tlen_r) ? K_BUILTIN : K_AT;
      M_EQ:      pend_k = K_ASSIGN;
      M_COLON1:  pend_k = K_COLON;
      M_MINUS:   pend_k = K_MINUS;
      M_LESS:    pend_k = K_LESS;
      M_GREATER: pend_k = K_GREATER;
      default:   pend_k = K_UNKNOWN;
    endcase
    cur = mk(pend_k, tline_r, tcol_r, tstart_r, tlen_r);

    mode_nxt   = mode_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    pos_nxt    = pos_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    kw_nxt     = kw_r;
    esc_nxt    = esc_r;
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    single     = '0;
    took       = 1'b0;
    cons       = 1'b0;
    fin        = 1'b0;
    fin_k      = K_UNKNOWN;
    to_idle    = 1'b0;

    if (is_end) begin
      // flush the pending token, then eof at the current position
      if (mode_r != M_IDLE) begin
        r0 = cur;
        n  = 2'd1;
      end
      if (n == 2'd0) begin
        r0 = mk(K_EOF, line_r, col_r, pos_r, 16'd0);
      end else begin
        r1 = mk(K_EOF, line_r, col_r, pos_r, 16'd0);
      end
      n          = n + 2'd1;
      mode_nxt   = M_IDLE;
      line_nxt   = LINE_WIDTH'(1);
      col_nxt    = LINE_WIDTH'(1);
      pos_nxt    = '0;
      tline_nxt  = LINE_WIDTH'(1);
      tcol_nxt   = LINE_WIDTH'(1);
      tstart_nxt = '0;
      tlen_nxt   = 16'd0;
      kw_nxt     = KW_ALL;
      esc_nxt    = 1'b0;
    end else if (mode_r == M_IDLE) begin
      to_idle = 1'b1;
    end else begin
      case (mode_r)
        M_NUMBER: begin
          if (is_digit(char_code) || (char_code == CH_DOT)) begin
            took     = 1'b1;
            tlen_nxt = len_inc;
          end
        end
        M_IDENT, M_ATWORD: begin
          if (is_word(char_code)) begin
            took     = 1'b1;
            kw_nxt   = kw_step(kw_r, tlen_r, char_code);
            tlen_nxt = len_inc;
          end
        end
        M_AT0: begin
          if (is_alpha(char_code)) begin
            took     = 1'b1;
            mode_nxt = M_ATWORD;
            kw_nxt   = kw_step(KW_BUILTINS, tlen_r, char_code);
            tlen_nxt = len_inc;
          end
        end
        M_STRING: begin
          took = 1'b1;
          if (esc_r) begin
            esc_nxt  = 1'b0;
            tlen_nxt = len_inc;
          end else if (char_code == CH_QUOTE) begin
            r0       = cur;
            n        = 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            if (char_code == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end
            tlen_nxt = len_inc;
          end
        end
        M_COLON1: begin
          if (char_code == CH_COLON) begin
            took     = 1'b1;
            mode_nxt = M_COLON2;
            tlen_nxt = len_inc;
          end
        end
        M_EQ: begin
          fin   = (char_code == CH_EQ);
          fin_k = K_EQUAL;
        end
        M_COLON2: begin
          fin   = (char_code == CH_EQ);
          fin_k = K_DEFINE;
        end
        M_BANG: begin
          fin   = (char_code == CH_EQ);
          fin_k = K_NOT_EQUAL;
        end
        M_MINUS: begin
          fin   = (char_code == CH_GT);
          fin_k = K_ARROW;
        end
        M_LESS: begin
          fin   = (char_code == CH_EQ);
          fin_k = K_LESS_EQUAL;
        end
        M_GREATER: begin
          fin   = (char_code == CH_EQ);
          fin_k = K_GREATER_EQUAL;
        end
        default: ;
      endcase
      if (fin) begin
        took     = 1'b1;
        r0       = mk(fin_k, tline_r, tcol_r, tstart_r, len_inc);
        n        = 2'd1;
        mode_nxt = M_IDLE;
        tlen_nxt = len_inc;
      end
      cons = took;
      // byte breaks off the pending token and starts the next one
      if (!took) begin
        r0       = cur;
        n        = 2'd1;
        mode_nxt = M_IDLE;
        to_idle  = 1'b1;
      end
    end

    if (to_idle) begin
      cons = 1'b1;
      if (!is_space(char_code)) begin
        tline_nxt  = line_r;
        tcol_nxt   = col_r;
        tstart_nxt = pos_r;
        tlen_nxt   = 16'd1;
        esc_nxt    = 1'b0;
        if (is_digit(char_code)) begin
          mode_nxt = M_NUMBER;
        end else if (is_alpha(char_code) || (char_code == CH_UNDER)) begin
          mode_nxt = M_IDENT;
          kw_nxt   = kw_step(KW_WORDS, 16'd0, char_code);
        end else if ((char_code == CH_QUOTE) || (char_code == CH_AT)) begin
          mode_nxt   = (char_code == CH_QUOTE) ? M_STRING : M_AT0;
          tlen_nxt   = 16'd0;
          tstart_nxt = pos_inc;
        end else if (char_code == CH_EQ) begin
          mode_nxt = M_EQ;
        end else if (char_code == CH_COLON) begin
          mode_nxt = M_COLON1;
        end else if (char_code == CH_BANG) begin
          mode_nxt = M_BANG;
        end else if (char_code == CH_MINUS) begin
          mode_nxt = M_MINUS;
        end else if (char_code == CH_LESS) begin
          mode_nxt = M_LESS;
        end else if (char_code == CH_GT) begin
          mode_nxt = M_GREATER;
        end else begin
          mode_nxt = M_IDLE;
          single   = mk(single_kind(char_code), line_r, col_r, pos_r, 16'd1);
          if (n == 2'd0) begin
            r0 = single;
          end else begin
            r1 = single;
          end
          n = n + 2'd1;
        end
      end
    end

    if (cons) begin
      pos_nxt  = pos_inc;
      line_nxt = line_cons;
      col_nxt  = col_cons;
    end

    if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end

    scan_o.r0    = r0;
    scan_o.r1    = r1;
    scan_o.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      line_r   <= LINE_WIDTH'(1);
      col_r    <= LINE_WIDTH'(1);
      pos_r    <= '0;
      tline_r  <= LINE_WIDTH'(1);
      tcol_r   <= LINE_WIDTH'(1);
      tstart_r <= '0;
      tlen_r   <= 16'd0;
      kw_r     <= KW_ALL;
      esc_r    <= 1'b0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      pos_r    <= pos_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      kw_r     <= kw_nxt;
      esc_r    <= esc_nxt;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_end) |=> (mode_r == M_IDLE && pos_r == '0 && line_r == LINE_WIDTH'(1)))
    else $error("position not back at start after end of source");

  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_end) |-> (scan_o.count != 2'd0))
    else $error("end of source gave no eof token");

  a_esc_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (mode_r == M_STRING))
    else $error("escape pending outside a string");

endmodule

// ----- sv/source_text_tokenizer_unit.sv -----
// top level of the source text tokenizer: scanner plus token output queue
//
// usage
//   in_chan carries one source byte per item (char_code) plus end_of_input;
//   a zero byte or end_of_input ends the source
//   out_chan carries tokens: kind, start line/column/offset, text length and
//   last_of_run, set on the final token caused by one input item
// timing
//   an accepted byte is scanned in the cycle it is accepted; its tokens are
//   registered into the token queue and leave it in order from its head
//   one byte per cycle while in_chan.ready is high; a byte that yields two
//   tokens (a pending token plus a single-character operator, or a pending
//   token plus eof) puts both in the queue, which hands them out one at a time
// reset
//   a clock edge with rst_n low empties the queue and returns line and column
//   to 1 and the byte offset to 0; no clearing pass is needed
// stall
//   tokens collect in a four-entry queue; in_chan.ready drops once fewer
//   than two entries are free, so nothing is lost while out_chan stalls
module source_text_tokenizer_unit import sttu_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned LINE_WIDTH     = 16
) (
  input logic        clk,
  input logic        rst_n,
  sttu_in_if.sink    in_chan,
  sttu_out_if.source out_chan
);

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic             in_fire, out_fire;
  scan_out_t        scan;
  res_t             queue_r [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  res_t             head;

  // room for the worst case of two tokens from one byte
  assign in_chan.ready = (cnt_r <= CNT_W'(RES_DEPTH - 2));
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_chan.valid && out_chan.ready;

  sttu_scan #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .LINE_WIDTH    (LINE_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .char_code   (in_chan.char_code),
    .end_of_input(in_chan.end_of_input),
    .scan_o      (scan)
  );

  // queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(scan.count);
      cnt_nxt    = cnt_nxt + CNT_W'(scan.count);
    end
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
      cnt_nxt    = cnt_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // token payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && (scan.count != 2'd0)) begin
      queue_r[wr_ptr_r] <= scan.r0;
    end
    if (in_fire && (scan.count == 2'd2)) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= scan.r1;
    end
  end

  assign head                  = queue_r[rd_ptr_r];
  assign out_chan.valid        = (cnt_r != '0);
  assign out_chan.token_kind   = head.token_kind;
  assign out_chan.start_line   = head.start_line;
  assign out_chan.start_column = head.start_column;
  assign out_chan.start_offset = head.start_offset;
  assign out_chan.text_length  = head.text_length;
  assign out_chan.last_of_run  = head.last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RES_DEPTH))
    else $error("token queue overfilled");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.token_kind == K_EOF) |-> out_chan.last_of_run)
    else $error("eof token not marked last of run");

  a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.end_of_input) |=> (cnt_r != '0))
    else $error("end of source left the queue empty");

endmodule
